// ===== src/psles_pkg.sv =====
package psles_pkg;

	localparam logic [2:0] CMD_SEL  = 3'd0;
	localparam logic [2:0] CMD_MISS = 3'd1;
	localparam logic [2:0] CMD_PREF = 3'd2;
	localparam logic [2:0] CMD_RES  = 3'd3;
	localparam logic [2:0] CMD_RUN  = 3'd4;

	localparam logic [1:0] RES_UNLOADED = 2'd0;
	localparam logic [1:0] RES_LOADING  = 2'd1;
	localparam logic [1:0] RES_RESIDENT = 2'd2;
	localparam logic [1:0] RES_EVICT    = 2'd3;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_EVICT = 2'd2;

	localparam logic [1:0] REG_ACTIVE = 2'd0;
	localparam logic [1:0] REG_MAXLD  = 2'd1;
	localparam logic [1:0] REG_BUDGET = 2'd2;
	localparam logic [1:0] REG_GRACE  = 2'd3;

	localparam logic [15:0] PRIO_ONE  = 16'd32768;
	localparam logic [15:0] PRIO_MISS = 16'd29491;
	localparam logic [15:0] PRIO_PREF = 16'd16384;
	localparam logic [31:0] NEVER     = 32'hffff_ffff;

	localparam int NUM_W = 33;
	localparam int DEN_W = 20;
	localparam int QUO_W = 14;

	typedef struct packed {
		logic [2:0]  mark;
		logic [1:0]  res;
		logic [31:0] touch;
		logic [31:0] lsel;
		logic [15:0] prio;
	} page_word_t;

	function automatic page_word_t eff_word(page_word_t raw, logic mark_ok, logic entry_ok);
		page_word_t w;
		w = raw;
		if (!mark_ok) begin
			w.mark = 3'd0;
		end
		if (!entry_ok) begin
			w.res   = RES_UNLOADED;
			w.touch = 32'd0;
			w.lsel  = NEVER;
		end
		return w;
	endfunction

endpackage

// ===== src/psles_ram.sv =====
module psles_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/psles_div.sv =====
module psles_div
	import psles_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quot
);

	logic [NUM_W-1:0]         rem_q;
	logic [NUM_W-1:0]         sh_q;
	logic [QUO_W-1:0]         quo_q;
	logic [$clog2(QUO_W)-1:0] cnt_q;
	logic                     busy_q;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num;
				sh_q   <= NUM_W'({den, {(QUO_W-1){1'b0}}});
				quo_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_q >= sh_q) begin
					rem_q <= rem_q - sh_q;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				sh_q  <= sh_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(QUO_W))'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== src/page_stream_load_evict_scheduler.sv =====
// Page residency scheduler. Mark and residency transactions update one page each. A run
// transaction scores every active page through the single page memory, sending a page
// whose priority decays through the serial divider, then walks all active pages once per
// request, and once more where a load or evict search ends with no page left to pick.
// Every request of a run is a result transaction; the final one has tlast set, and a run
// with no request gives one summary transaction of kind zero.
module page_stream_load_evict_scheduler
	import psles_pkg::*;
#(
	parameter int PAGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// page, frame_number, residency, touched_frame
	input  logic [71:0] s_axis_tdata,
	// command
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// page_out, priority_res, resident_count, loading_count
	output logic [39:0] m_axis_tdata,
	// kind
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PW = $clog2(PAGES);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CMD, ST_SC_RD, ST_SC_DAT, ST_SC_DIV, ST_SC_WR,
		ST_LD_START, ST_SCAN, ST_FOUND, ST_EV_CHK, ST_EMIT
	} state_t;

	state_t state_q;

	logic [6:0]  active_q, maxld_q, budget_q;
	logic [15:0] grace_q;

	logic [2:0]  cmd_q;
	logic [PW-1:0] pg_q;
	logic [1:0]  res_in_q;
	logic [31:0] touch_in_q;
	logic [31:0] frame_q;
	logic [6:0]  cnt_q;
	logic        vld_s1;
	logic [PW-1:0] idx_s1;
	page_word_t  word_q;
	logic [6:0]  res_cnt_q, ld_cnt_q, nload_q;
	logic [7:0]  need_q, done_q;
	logic        evict_mode_q;
	logic        best_v_q;
	logic [PW-1:0] best_idx_q;
	logic [15:0] best_prio_q;
	logic [31:0] best_touch_q;
	logic        pend_v_q;
	logic [1:0]  pend_kind_q;
	logic [PW-1:0] pend_page_q;
	logic [15:0] pend_prio_q;
	logic        fin_q;
	logic [PAGES-1:0] mv_q, ev_q, used_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [5:0]  out_page_q;
	logic [15:0] out_prio_q;
	logic [6:0]  out_rc_q, out_lc_q;
	logic        out_last_q;

	logic [6:0]  n_w;
	logic [2:0]  in_cmd;
	logic [5:0]  in_page;
	logic        in_range;
	logic [PW-1:0] rd_idx, raddr, waddr;
	logic        we;
	page_word_t  rdata_raw, rd_w, wdata, cmd_w, sc_w;
	logic [31:0] age;
	logic [15:0] diff;
	logic        decay_go;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic        div_start, div_done;
	logic [QUO_W-1:0] div_quot;
	logic        out_free;
	logic        out_load;
	logic        load_hit, evict_hit;
	logic [7:0]  sum_w;

	assign n_w      = (active_q > 7'(PAGES)) ? 7'(PAGES) : active_q;
	assign in_cmd   = s_axis_tuser;
	assign in_page  = s_axis_tdata[5:0];
	assign in_range = {1'b0, in_page} < 7'(PAGES);
	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_EMIT) && out_free && (fin_q || pend_v_q);

	assign rd_idx = (state_q == ST_CMD) ? pg_q :
		(state_q == ST_SCAN) ? idx_s1 : cnt_q[PW-1:0];
	assign rd_w   = eff_word(rdata_raw, mv_q[rd_idx], ev_q[rd_idx]);
	assign raddr  = (state_q == ST_IDLE) ? in_page[PW-1:0] : cnt_q[PW-1:0];

	always_comb begin
		cmd_w = rd_w;
		if (cmd_q == CMD_RES) begin
			cmd_w.res   = res_in_q;
			cmd_w.touch = touch_in_q;
		end else begin
			cmd_w.mark = rd_w.mark | (3'd1 << cmd_q[1:0]);
		end
	end

	assign age     = frame_q - rd_w.lsel;
	assign diff    = grace_q - age[15:0];
	assign div_num = {({2'b00, diff} + {1'b0, diff, 1'b0}), 15'd0};
	assign div_den = {1'b0, grace_q, 3'd0} + {3'd0, grace_q, 1'b0};

	always_comb begin
		sc_w     = rd_w;
		decay_go = 1'b0;
		sc_w.prio = 16'd0;
		if (rd_w.mark[0]) begin
			sc_w.prio = PRIO_ONE;
			sc_w.lsel = frame_q;
		end else if (rd_w.mark[1]) begin
			sc_w.prio = PRIO_MISS;
		end else if (rd_w.mark[2]) begin
			sc_w.prio = PRIO_PREF;
		end else if (rd_w.lsel != NEVER && grace_q != 16'd0 && age <= {16'd0, grace_q}) begin
			decay_go = 1'b1;
		end
	end

	assign div_start = (state_q == ST_SC_DAT) && decay_go;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[PW-1:0];
		wdata = word_q;
		case (state_q)
			ST_CMD: begin
				we    = 1'b1;
				waddr = pg_q;
				wdata = cmd_w;
			end
			ST_SC_DAT: begin
				we    = !decay_go;
				wdata = sc_w;
			end
			ST_SC_WR: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign load_hit = vld_s1 && !used_q[idx_s1] && rd_w.prio != 16'd0 &&
		(rd_w.res == RES_UNLOADED || rd_w.res == RES_EVICT) &&
		(!best_v_q || rd_w.prio > best_prio_q);
	assign evict_hit = vld_s1 && !used_q[idx_s1] && rd_w.prio == 16'd0 && rd_w.res[1] &&
		(!best_v_q || rd_w.touch < best_touch_q);
	assign sum_w = {1'b0, res_cnt_q} + {1'b0, nload_q};

	psles_ram #(
		.WIDTH($bits(page_word_t)),
		.DEPTH(PAGES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	psles_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= 7'd64;
			maxld_q      <= 7'd8;
			budget_q     <= 7'd32;
			grace_q      <= 16'd60;
			mv_q         <= '0;
			ev_q         <= '0;
			used_q       <= '0;
			vld_s1       <= 1'b0;
			best_v_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			fin_q        <= 1'b0;
			evict_mode_q <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ACTIVE: active_q <= cfg_data[6:0];
					REG_MAXLD:  maxld_q  <= cfg_data[6:0];
					REG_BUDGET: budget_q <= cfg_data[6:0];
					default:    grace_q  <= cfg_data;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q      <= in_cmd;
						pg_q       <= in_page[PW-1:0];
						res_in_q   <= s_axis_tdata[39:38];
						touch_in_q <= s_axis_tdata[71:40];
						frame_q    <= s_axis_tdata[37:6];
						if (in_cmd <= CMD_RES && in_range) begin
							state_q <= ST_CMD;
						end else if (in_cmd == CMD_RUN) begin
							res_cnt_q <= '0;
							ld_cnt_q  <= '0;
							used_q    <= '0;
							pend_v_q  <= 1'b0;
							cnt_q     <= '0;
							state_q   <= (n_w == 7'd0) ? ST_LD_START : ST_SC_RD;
						end
					end
				end
				ST_CMD: begin
					mv_q[pg_q] <= 1'b1;
					ev_q[pg_q] <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_SC_RD: begin
					state_q <= ST_SC_DAT;
				end
				ST_SC_DAT: begin
					if (rd_w.res[1]) begin
						res_cnt_q <= res_cnt_q + 1'b1;
					end else if (rd_w.res == RES_LOADING) begin
						ld_cnt_q <= ld_cnt_q + 1'b1;
					end
					if (decay_go) begin
						word_q  <= sc_w;
						state_q <= ST_SC_DIV;
					end else begin
						mv_q[cnt_q[PW-1:0]] <= 1'b1;
						ev_q[cnt_q[PW-1:0]] <= 1'b1;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= (cnt_q + 1'b1 == n_w) ? ST_LD_START : ST_SC_RD;
					end
				end
				ST_SC_DIV: begin
					if (div_done) begin
						word_q.prio <= 16'(div_quot);
						state_q     <= ST_SC_WR;
					end
				end
				ST_SC_WR: begin
					mv_q[cnt_q[PW-1:0]] <= 1'b1;
					ev_q[cnt_q[PW-1:0]] <= 1'b1;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q + 1'b1 == n_w) ? ST_LD_START : ST_SC_RD;
				end
				ST_LD_START: begin
					nload_q      <= '0;
					evict_mode_q <= 1'b0;
					cnt_q        <= '0;
					best_v_q     <= 1'b0;
					vld_s1       <= 1'b0;
					state_q      <= (maxld_q == 7'd0) ? ST_EV_CHK : ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q < n_w) begin
						vld_s1 <= 1'b1;
						idx_s1 <= cnt_q[PW-1:0];
						cnt_q  <= cnt_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (evict_mode_q ? evict_hit : load_hit) begin
						best_v_q     <= 1'b1;
						best_idx_q   <= idx_s1;
						best_prio_q  <= rd_w.prio;
						best_touch_q <= rd_w.touch;
					end
					if (cnt_q == n_w && !vld_s1) begin
						state_q <= ST_FOUND;
					end
				end
				ST_FOUND: begin
					if (best_v_q) begin
						used_q[best_idx_q] <= 1'b1;
						if (evict_mode_q) begin
							done_q <= done_q + 1'b1;
						end else begin
							nload_q <= nload_q + 1'b1;
						end
						fin_q   <= 1'b0;
						state_q <= ST_EMIT;
					end else if (evict_mode_q) begin
						fin_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_EV_CHK;
					end
				end
				ST_EV_CHK: begin
					if (sum_w > {1'b0, budget_q}) begin
						need_q       <= sum_w - {1'b0, budget_q};
						done_q       <= '0;
						evict_mode_q <= 1'b1;
						cnt_q        <= '0;
						best_v_q     <= 1'b0;
						vld_s1       <= 1'b0;
						state_q      <= ST_SCAN;
					end else begin
						fin_q   <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (fin_q) begin
						if (out_free) begin
							out_kind_q  <= pend_v_q ? pend_kind_q : KIND_NONE;
							out_page_q  <= pend_v_q ? 6'(pend_page_q) : 6'd0;
							out_prio_q  <= pend_v_q ? pend_prio_q : 16'd0;
							out_rc_q    <= res_cnt_q;
							out_lc_q    <= ld_cnt_q;
							out_last_q  <= 1'b1;
							pend_v_q    <= 1'b0;
							mv_q        <= '0;
							state_q     <= ST_IDLE;
						end
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_kind_q  <= pend_kind_q;
							out_page_q  <= 6'(pend_page_q);
							out_prio_q  <= pend_prio_q;
							out_rc_q    <= res_cnt_q;
							out_lc_q    <= ld_cnt_q;
							out_last_q  <= 1'b0;
						end
						pend_v_q    <= 1'b1;
						pend_kind_q <= evict_mode_q ? KIND_EVICT : KIND_LOAD;
						pend_page_q <= best_idx_q;
						pend_prio_q <= evict_mode_q ? 16'd0 : best_prio_q;
						cnt_q       <= '0;
						best_v_q    <= 1'b0;
						vld_s1      <= 1'b0;
						if (evict_mode_q) begin
							if (done_q < need_q) begin
								state_q <= ST_SCAN;
							end else begin
								fin_q <= 1'b1;
							end
						end else begin
							state_q <= (nload_q < maxld_q) ? ST_SCAN : ST_EV_CHK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_lc_q, out_rc_q, out_prio_q, out_page_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import psles_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  pg;
		logic [15:0] prio;
		logic [6:0]  rcnt;
		logic [6:0]  lcnt;
		logic        lst;
	} req_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [5:0]  pg;
		logic [31:0] frame;
		logic [1:0]  res;
		logic [31:0] touch;
		logic        has_exp;
		req_t        exp_req;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	page_stream_load_evict_scheduler dut (.*);

	localparam int NPAGE = 64;
	localparam logic [2:0] CMD_BAD_LO = 3'd5;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;
	localparam int IDLE_LIMIT = 200000;

	logic [6:0]  act_pages;
	logic [6:0]  load_cap;
	logic [6:0]  budget;
	logic [15:0] grace;
	logic [2:0]  marks [NPAGE];
	logic [31:0] sel_frame [NPAGE];
	logic [1:0]  page_state [NPAGE];
	logic [31:0] touch_frame [NPAGE];

	req_t pending_reqs[$];
	int   mismatches;
	int   idle_cycles;
	int   recv_wait;
	bit   hold_off;
	bit   check_row;
	req_t row_exp;

	int settings [4][4] = '{'{64, 8, 32, 60}, '{1, 0, 0, 1}, '{5, 64, 2, 65535},
	                        '{127, 3, 64, 0}};

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [15:0] page_priority(int i, logic [31:0] frame);
		logic [31:0] age;
		logic [63:0] num;
		if (marks[i][0])
			return PRIO_ONE;
		if (marks[i][1])
			return PRIO_MISS;
		if (marks[i][2])
			return PRIO_PREF;
		if (sel_frame[i] == NEVER || grace == 16'd0)
			return 16'd0;
		age = frame - sel_frame[i];
		if (age > {16'd0, grace})
			return 16'd0;
		num = 64'd98304 * ({48'd0, grace} - {32'd0, age});
		return 16'(num / (64'd10 * {48'd0, grace}));
	endfunction

	task automatic schedule_frame(logic [31:0] frame);
		int n, res, ld, nload, need, done, best;
		logic [15:0] prio [NPAGE];
		bit taken [NPAGE];
		req_t r;
		req_t out[$];
		n = act_pages < NPAGE ? int'(act_pages) : NPAGE;
		res = 0;
		ld = 0;
		nload = 0;
		for (int i = 0; i < NPAGE; i++)
			taken[i] = 0;
		for (int i = 0; i < n; i++) begin
			prio[i] = page_priority(i, frame);
			if (marks[i][0])
				sel_frame[i] = frame;
			if (page_state[i] >= RES_RESIDENT)
				res++;
			else if (page_state[i] == RES_LOADING)
				ld++;
		end
		while (nload < load_cap) begin
			best = -1;
			for (int i = 0; i < n; i++) begin
				if (taken[i] || prio[i] == 16'd0 ||
				    (page_state[i] != RES_UNLOADED && page_state[i] != RES_EVICT))
					continue;
				if (best < 0 || prio[i] > prio[best])
					best = i;
			end
			if (best < 0)
				break;
			taken[best] = 1;
			r = '{KIND_LOAD, 6'(best), prio[best], 7'(res), 7'(ld), 1'b0};
			out = {out, r};
			nload++;
		end
		if (res + nload > budget) begin
			need = res + nload - budget;
			done = 0;
			while (done < need) begin
				best = -1;
				for (int i = 0; i < n; i++) begin
					if (taken[i] || prio[i] != 16'd0 || page_state[i] < RES_RESIDENT)
						continue;
					if (best < 0 || touch_frame[i] < touch_frame[best])
						best = i;
				end
				if (best < 0)
					break;
				taken[best] = 1;
				r = '{KIND_EVICT, 6'(best), 16'd0, 7'(res), 7'(ld), 1'b0};
				out = {out, r};
				done++;
			end
		end
		if (out.size() == 0) begin
			r = '{KIND_NONE, 6'd0, 16'd0, 7'(res), 7'(ld), 1'b0};
			out = {out, r};
		end
		out[out.size() - 1].lst = 1'b1;
		foreach (out[k])
			pending_reqs = {pending_reqs, out[k]};
		for (int i = 0; i < NPAGE; i++)
			marks[i] = 3'd0;
	endtask

	task automatic apply_command(stim_row_t row);
		case (row.cmd)
			CMD_SEL, CMD_MISS, CMD_PREF: marks[row.pg][row.cmd] = 1'b1;
			CMD_RES: begin
				page_state[row.pg] = row.res;
				touch_frame[row.pg] = row.touch;
			end
			CMD_RUN: schedule_frame(row.frame);
			default: ;
		endcase
	endtask

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(stim_row_t row);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			wait_cycles(gap);
		end
		s_axis_tuser <= row.cmd;
		s_axis_tdata <= {row.touch, row.res, row.frame, row.pg};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		check_row = row.has_exp;
		row_exp = row.exp_req;
		apply_command(row);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_reqs.size() != 0)
			@(posedge clk);
		wait_cycles(NPAGE * 4 + 50);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ACTIVE: act_pages = val[6:0];
			REG_MAXLD:  load_cap = val[6:0];
			REG_BUDGET: budget = val[6:0];
			default:    grace = val;
		endcase
		@(posedge clk);
	endtask

	function automatic stim_row_t mk(logic [2:0] c, logic [5:0] p, logic [31:0] f,
	                                 logic [1:0] rs, logic [31:0] t);
		stim_row_t row;
		row.cmd = c;
		row.pg = p;
		row.frame = f;
		row.res = rs;
		row.touch = t;
		row.has_exp = 1'b0;
		row.exp_req = '0;
		return row;
	endfunction

	function automatic stim_row_t rand_row(int runs_pct, int span);
		stim_row_t row;
		int r;
		r = $urandom_range(0, 99);
		row = mk(CMD_SEL, 6'($urandom_range(0, span - 1)), $urandom, 2'($urandom),
		         $urandom);
		if ($urandom_range(0, 3) == 0)
			row.frame = sel_frame[row.pg] + $urandom_range(0, 70);
		if (r < runs_pct)
			row.cmd = CMD_RUN;
		else if (r < runs_pct + 20)
			row.cmd = CMD_RES;
		else if (r < 97)
			row.cmd = 3'($urandom_range(CMD_SEL, CMD_PREF));
		else
			row.cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
		return row;
	endfunction

	// receiver side
	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_wait <= 0;
		end else if (hold_off) begin
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			w = $urandom_range(0, 9);
			recv_wait <= w;
			m_axis_tready <= (w == 0);
		end else if (recv_wait != 0) begin
			recv_wait <= recv_wait - 1;
			m_axis_tready <= (recv_wait == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		req_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6],
			        m_axis_tdata[28:22], m_axis_tdata[35:29], m_axis_tlast};
			if (pending_reqs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction %p", got);
			end else begin
				want = pending_reqs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// directed cases: summary after reset is checked by value too
	stim_row_t table_rows[$];

	task automatic add_row(stim_row_t row);
		table_rows = {table_rows, row};
	endtask

	initial begin
		stim_row_t row;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_off = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		act_pages = 7'd64;
		load_cap = 7'd8;
		budget = 7'd32;
		grace = 16'd60;
		for (int i = 0; i < NPAGE; i++) begin
			marks[i] = 3'd0;
			sel_frame[i] = NEVER;
			page_state[i] = RES_UNLOADED;
			touch_frame[i] = 32'd0;
		end
		wait_cycles(8);
		arst_n <= 1'b1;
		wait_cycles(2);

		row = mk(CMD_RUN, 6'd0, 32'd0, RES_UNLOADED, 32'd0);
		row.has_exp = 1'b1;
		row.exp_req = '{KIND_NONE, 6'd0, 16'd0, 7'd0, 7'd0, 1'b1};
		add_row(row);
		add_row(mk(CMD_SEL, 6'd63, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_MISS, 6'd0, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_PREF, 6'd5, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RES, 6'd7, 32'd0, RES_LOADING, 32'd0));
		add_row(mk(CMD_RES, 6'd9, 32'd0, RES_RESIDENT, 32'hffffffff));
		add_row(mk(CMD_RES, 6'd10, 32'd0, RES_EVICT, 32'd3));
		add_row(mk(CMD_BAD_LO, 6'd1, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_BAD_HI, 6'd2, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RUN, 6'd0, 32'd100, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RUN, 6'd0, 32'd130, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RUN, 6'd0, 32'd160, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RUN, 6'd0, 32'd161, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_SEL, 6'd3, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RUN, 6'd0, 32'hffffffff, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RUN, 6'd0, 32'd5, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_SEL, 6'd0, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_MISS, 6'd0, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_PREF, 6'd0, 32'd0, RES_UNLOADED, 32'd0));
		add_row(mk(CMD_RUN, 6'd0, 32'd6, RES_UNLOADED, 32'd0));
		foreach (table_rows[k])
			send_item(table_rows[k]);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			int span;
			int idx;
			idx = ph % 4;
			write_reg(REG_ACTIVE, 16'(settings[idx][0]));
			write_reg(REG_MAXLD, 16'(settings[idx][1]));
			write_reg(REG_BUDGET, 16'(settings[idx][2]));
			write_reg(REG_GRACE, ph == 4 ? 16'($urandom_range(1, 200)) :
			          16'(settings[idx][3]));
			span = (ph == 2) ? 8 : 64;
			if (ph == 1)
				fork
					begin
						hold_off = 1'b1;
						wait_cycles(600);
						hold_off = 1'b0;
					end
				join_none
			for (int k = 0; k < 80; k++)
				send_item(rand_row(ph == 1 ? 30 : 12, span));
			drain();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// directed rows with a typed-in result
	always @(posedge clk) begin
		if (check_row) begin
			check_row <= 1'b0;
			if (pending_reqs.size() == 0 || pending_reqs[0] !== row_exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row: expected %p", row_exp);
			end
		end
	end

endmodule

// ===== sim.f =====
src/psles_pkg.sv
src/psles_ram.sv
src/psles_div.sv
src/page_stream_load_evict_scheduler.sv
test/tb_top.sv
